// ----- hw/rtl/hmle_pkg.sv -----
// Package for the heartbeat membership / leader election block.
// Holds item structs, command, status and peer-state codes. No dependencies.
`default_nettype none
package hmle_pkg;
  localparam logic [1:0] CMD_ADD  = 2'd0;
  localparam logic [1:0] CMD_HB   = 2'd1;
  localparam logic [1:0] CMD_PONG = 2'd2;
  localparam logic [1:0] CMD_TICK = 2'd3;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_DUP   = 2'd2;
  localparam logic [1:0] ST_NOTFD = 2'd3;

  localparam logic [1:0] PS_ALIVE   = 2'd0;
  localparam logic [1:0] PS_SUSPECT = 2'd1;
  localparam logic [1:0] PS_DEAD    = 2'd2;

  localparam logic [1:0] CFG_SELF = 2'd0;
  localparam logic [1:0] CFG_SUSP = 2'd1;
  localparam logic [1:0] CFG_HB   = 2'd2;

  localparam int MASK_BITS = 8;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] node_id;
    logic [31:0] peer_ip;
    logic [15:0] peer_port;
    logic [31:0] now_seconds;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] leader_node;
    logic        self_is_leader;
    logic [31:0] view_number;
    logic [3:0]  alive_count;
    logic [7:0]  ping_mask;
    logic [7:0]  dead_mask;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // latch item, start
    logic scan;   // visit current slot
    logic apply;  // commit lookup result
    logic elect;  // visit slot for election/count
    logic finish; // finish election, emit
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic last;   // current slot is the last one to visit
    logic empty;  // no slots to visit
  } sts_t;
endpackage
`default_nettype wire

// ----- hw/rtl/heartbeat_membership_leader_elect.sv -----
// Sequence from start to out_valid: load, lookup/aging scan over the peer table, apply,
// election scan over the updated table, finish; out_valid is registered from finish.
// A new item is taken only while busy is low, once the previous item has finished.
// Reset (synchronous, rst_n low): table empty, leader cleared and flagged as self, view = 1.
// Results are strobed for one cycle; the receiver cannot stall.
// Depends on hmle_pkg, hmle_ctrl, hmle_dp.
`default_nettype none
module heartbeat_membership_leader_elect #(
  parameter int MAX_PEERS = 8,
  parameter int ID_BITS = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire hmle_pkg::in_item_t  in_item,
  output hmle_pkg::out_item_t      out_item,
  output logic                     out_valid,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [63:0]         cfg_data
);
  import hmle_pkg::*;

  ctl_t ctl;
  sts_t sts;
  logic [ID_BITS-1:0] self_id_r;
  logic [15:0] susp_r, hb_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      self_id_r <= '0;
      susp_r <= 16'd30;
      hb_r <= 16'd10;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SELF: self_id_r <= cfg_data[ID_BITS-1:0];
        CFG_SUSP: susp_r <= cfg_data[15:0];
        CFG_HB: hb_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  hmle_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .sts(sts), .ctl(ctl), .busy(busy)
  );

  hmle_dp #(.MAX_PEERS(MAX_PEERS), .ID_BITS(ID_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .sts(sts), .in_item(in_item),
    .self_id(self_id_r), .susp_sec(susp_r), .hb_sec(hb_r),
    .out_item(out_item), .out_valid(out_valid)
  );

`ifndef ASSERT_OFF
  a_one_phase: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctl.load, ctl.scan, ctl.apply, ctl.elect, ctl.finish}))
    else $error("multiple phases active");
  a_out_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result while busy");
  a_alive_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.alive_count != 4'd0)
    else $error("alive count zero");
`endif
endmodule
`default_nettype wire

// ----- hw/rtl/hmle_ctrl.sv -----
// Controller state machine for the membership block.
// Depends on hmle_pkg; drives hmle_dp through ctl_t and reads sts_t.
`default_nettype none
module hmle_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire hmle_pkg::sts_t  sts,
  output hmle_pkg::ctl_t       ctl,
  output logic                 busy
);
  import hmle_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_APPLY = 3'd2;
  localparam logic [2:0] S_ELECT = 3'd3;
  localparam logic [2:0] S_FIN = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    ctl = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.load = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.empty) begin
          state_nxt = S_APPLY;
        end else begin
          ctl.scan = 1'b1;
          if (sts.last) state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        ctl.apply = 1'b1;
        state_nxt = S_ELECT;
      end
      S_ELECT: begin
        if (sts.empty) begin
          state_nxt = S_FIN;
        end else begin
          ctl.elect = 1'b1;
          if (sts.last) state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        ctl.finish = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end
endmodule
`default_nettype wire

// ----- hw/rtl/hmle_dp.sv -----
// Datapath: peer table, slot walker, aging, election and result register.
// Depends on hmle_pkg; sequenced by hmle_ctrl.
`default_nettype none
module hmle_dp #(
  parameter int MAX_PEERS = 8,
  parameter int ID_BITS = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire hmle_pkg::ctl_t      ctl,
  output hmle_pkg::sts_t           sts,
  input  wire hmle_pkg::in_item_t  in_item,
  input  wire logic [ID_BITS-1:0]  self_id,
  input  wire logic [15:0]         susp_sec,
  input  wire logic [15:0]         hb_sec,
  output hmle_pkg::out_item_t      out_item,
  output logic                     out_valid
);
  import hmle_pkg::*;

  localparam int SW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
  localparam int TW = $clog2(MAX_PEERS + 1);

  logic [ID_BITS-1:0] ident_r [MAX_PEERS];
  logic [31:0] addr_r [MAX_PEERS];
  logic [15:0] udp_r [MAX_PEERS];
  logic [31:0] seen_t_r [MAX_PEERS];
  logic [1:0]  pst_r [MAX_PEERS];
  logic [MAX_PEERS-1:0] seen_r;

  logic [TW-1:0] total_r;
  logic [ID_BITS-1:0] leader_r;
  logic leader_self_r;
  logic [31:0] view_r;
  logic [31:0] last_ping_r;

  in_item_t item_r;
  logic [ID_BITS-1:0] id_w;
  logic [SW-1:0] idx_r;
  logic id_hit_r, ad_hit_r;
  logic [SW-1:0] id_slot_r, ad_slot_r;
  logic [1:0] status_r;
  logic run_r;
  logic [ID_BITS-1:0] best_r;
  logic [3:0] alive_r;
  logic [7:0] ping_r, dead_r;
  out_item_t out_r;
  logic out_v_r;

  assign id_w = item_r.node_id[ID_BITS-1:0];

  assign sts.empty = (total_r == '0);
  assign sts.last = (TW'(idx_r) == TW'(total_r - 1'b1));

  // per-slot aging of the current slot
  logic [31:0] age;
  logic [16:0] t2;
  logic [1:0] ns;
  always_comb begin
    age = item_r.now_seconds - seen_t_r[idx_r];
    t2 = {1'b0, susp_sec} << 1;
    if (age < {16'd0, susp_sec}) ns = PS_ALIVE;
    else if (age < {15'd0, t2}) ns = PS_SUSPECT;
    else ns = PS_DEAD;
  end

  logic [1:0] cur_st;
  logic [SW-1:0] hit_slot;
  assign cur_st = pst_r[idx_r];
  assign hit_slot = id_hit_r ? id_slot_r : ad_slot_r;

  logic [31:0] hb_age;
  assign hb_age = item_r.now_seconds - last_ping_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      leader_r <= '0;
      leader_self_r <= 1'b1;
      view_r <= 32'd1;
      last_ping_r <= '0;
      seen_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= 1'b0;
      if (ctl.load) begin
        item_r <= in_item;
        idx_r <= '0;
        id_hit_r <= 1'b0;
        ad_hit_r <= 1'b0;
        status_r <= ST_DONE;
        run_r <= 1'b0;
        ping_r <= '0;
        dead_r <= '0;
      end
      if (ctl.scan) begin
        if (item_r.cmd == CMD_TICK) begin
          if (hb_age >= {16'd0, hb_sec} && cur_st != PS_DEAD && 32'(idx_r) < MASK_BITS)
            ping_r[3'(idx_r)] <= 1'b1;
          if (seen_r[idx_r] && ns != cur_st) begin
            pst_r[idx_r] <= ns;
            run_r <= 1'b1;
            if (ns == PS_DEAD && 32'(idx_r) < MASK_BITS) dead_r[3'(idx_r)] <= 1'b1;
          end
        end else begin
          if (!id_hit_r && ident_r[idx_r] == id_w) begin
            id_hit_r <= 1'b1;
            id_slot_r <= idx_r;
          end
          if (!ad_hit_r && addr_r[idx_r] == item_r.peer_ip &&
              udp_r[idx_r] == item_r.peer_port) begin
            ad_hit_r <= 1'b1;
            ad_slot_r <= idx_r;
          end
        end
        if (!sts.last) idx_r <= idx_r + 1'b1;
      end
      if (ctl.apply) begin
        idx_r <= '0;
        best_r <= self_id;
        alive_r <= 4'd1;
        case (item_r.cmd)
          CMD_ADD: begin
            if (total_r >= TW'(MAX_PEERS)) status_r <= ST_FULL;
            else if (id_hit_r || id_w == self_id) status_r <= ST_DUP;
            else begin
              ident_r[total_r[SW-1:0]] <= id_w;
              addr_r[total_r[SW-1:0]] <= item_r.peer_ip;
              udp_r[total_r[SW-1:0]] <= item_r.peer_port;
              seen_t_r[total_r[SW-1:0]] <= '0;
              seen_r[total_r[SW-1:0]] <= 1'b0;
              pst_r[total_r[SW-1:0]] <= PS_SUSPECT;
              total_r <= total_r + 1'b1;
              run_r <= 1'b1;
            end
          end
          CMD_HB, CMD_PONG: begin
            if (id_hit_r || (item_r.cmd == CMD_PONG && ad_hit_r)) begin
              if (!id_hit_r) ident_r[hit_slot] <= id_w;
              seen_t_r[id_hit_r ? id_slot_r : hit_slot] <= item_r.now_seconds;
              seen_r[id_hit_r ? id_slot_r : hit_slot] <= 1'b1;
              if (pst_r[id_hit_r ? id_slot_r : hit_slot] != PS_ALIVE) begin
                pst_r[id_hit_r ? id_slot_r : hit_slot] <= PS_ALIVE;
                run_r <= 1'b1;
              end
            end else begin
              status_r <= ST_NOTFD;
            end
          end
          CMD_TICK: begin
            if (hb_age >= {16'd0, hb_sec}) last_ping_r <= item_r.now_seconds;
          end
          default: status_r <= ST_DONE;
        endcase
      end
      if (ctl.elect) begin
        if (cur_st == PS_ALIVE) begin
          if (ident_r[idx_r] < best_r) best_r <= ident_r[idx_r];
          if (alive_r != 4'd15) alive_r <= alive_r + 1'b1;
        end
        if (!sts.last) idx_r <= idx_r + 1'b1;
      end
      if (ctl.finish) begin
        out_v_r <= 1'b1;
        out_r.status <= status_r;
        out_r.alive_count <= alive_r;
        out_r.ping_mask <= ping_r;
        out_r.dead_mask <= dead_r;
        out_r.leader_node <= 64'(run_r ? best_r : leader_r);
        out_r.self_is_leader <= run_r ? (best_r == self_id) : leader_self_r;
        out_r.view_number <= (run_r && best_r != leader_r) ? view_r + 1'b1 : view_r;
        if (run_r) begin
          if (best_r != leader_r) view_r <= view_r + 1'b1;
          leader_r <= best_r;
          leader_self_r <= (best_r == self_id);
        end
      end
    end
  end

  assign out_item = out_r;
  assign out_valid = out_v_r;
endmodule
`default_nettype wire
